>>> design/gpiofs_pkg.sv
package gpiofs_pkg;

	localparam int LOW_WIDTH     = 32;
	localparam int HIGH_WIDTH    = 22;
	localparam int FN_WIDTH      = 3;
	localparam int PINS_PER_FSEL = 10;
	localparam int OFFSET_WIDTH  = 6;

	localparam logic [OFFSET_WIDTH-1:0] FSEL_WORDS = 6'd6;
	localparam logic [OFFSET_WIDTH-1:0] WORD_SET0  = 6'd7;
	localparam logic [OFFSET_WIDTH-1:0] WORD_SET1  = 6'd8;
	localparam logic [OFFSET_WIDTH-1:0] WORD_CLR0  = 6'd10;
	localparam logic [OFFSET_WIDTH-1:0] WORD_CLR1  = 6'd11;
	localparam logic [OFFSET_WIDTH-1:0] WORD_LEV0  = 6'd13;
	localparam logic [OFFSET_WIDTH-1:0] WORD_LEV1  = 6'd14;

	localparam logic [FN_WIDTH-1:0] CODE_OUTPUT = 3'd1;

	typedef struct packed {
		logic                    wr;
		logic [OFFSET_WIDTH-1:0] offset;
		logic [LOW_WIDTH-1:0]    wdata;
		logic [LOW_WIDTH-1:0]    lev_lo;
		logic [HIGH_WIDTH-1:0]   lev_hi;
	} gpiofs_acc_t;

	typedef struct packed {
		logic [LOW_WIDTH-1:0]  read_data;
		logic [LOW_WIDTH-1:0]  drive_low;
		logic [HIGH_WIDTH-1:0] drive_high;
		logic [LOW_WIDTH-1:0]  enable_low;
		logic [HIGH_WIDTH-1:0] enable_high;
	} gpiofs_res_t;

endpackage

>>> design/gpiofs_regfile.sv
module gpiofs_regfile import gpiofs_pkg::*; #(
	parameter int NUM_PINS = 54
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        upd,
	input  gpiofs_acc_t acc,
	output gpiofs_res_t res
);

	localparam int HI = NUM_PINS - LOW_WIDTH;
	localparam logic [63:0] HI_MASK = (64'd1 << HI) - 64'd1;

	logic [FN_WIDTH-1:0] fn_q    [NUM_PINS];
	logic [FN_WIDTH-1:0] fn_next [NUM_PINS];
	logic [NUM_PINS-1:0] latch_q;
	logic [NUM_PINS-1:0] latch_next;
	logic [NUM_PINS-1:0] set_v;
	logic [NUM_PINS-1:0] clr_v;
	logic [NUM_PINS-1:0] en;
	logic [LOW_WIDTH-1:0] fsel_rd;
	logic [LOW_WIDTH-1:0] rd;
	logic [63:0] latch_ext;
	logic [63:0] en_ext;

	for (genvar p = 0; p < NUM_PINS; p++) begin : g_pin
		localparam int W = p / PINS_PER_FSEL;
		localparam int K = p % PINS_PER_FSEL;
		if (W < int'(FSEL_WORDS)) begin : g_wr
			assign fn_next[p] = (acc.wr && acc.offset == OFFSET_WIDTH'(W)) ?
				acc.wdata[FN_WIDTH*K +: FN_WIDTH] : fn_q[p];
		end else begin : g_ro
			assign fn_next[p] = fn_q[p];
		end
		assign en[p] = (fn_next[p] == CODE_OUTPUT);
	end

	always_comb begin
		fsel_rd = '0;
		for (int w = 0; w < int'(FSEL_WORDS); w++) begin
			for (int k = 0; k < PINS_PER_FSEL; k++) begin
				if ((w * PINS_PER_FSEL + k) < NUM_PINS && acc.offset == OFFSET_WIDTH'(w)) begin
					fsel_rd[FN_WIDTH*k +: FN_WIDTH] = fn_q[w * PINS_PER_FSEL + k];
				end
			end
		end
	end

	always_comb begin
		set_v = '0;
		clr_v = '0;
		if (acc.wr) begin
			case (acc.offset)
				WORD_SET0: set_v[LOW_WIDTH-1:0] = acc.wdata;
				WORD_SET1: set_v[NUM_PINS-1:LOW_WIDTH] = acc.wdata[HI-1:0];
				WORD_CLR0: clr_v[LOW_WIDTH-1:0] = acc.wdata;
				WORD_CLR1: clr_v[NUM_PINS-1:LOW_WIDTH] = acc.wdata[HI-1:0];
				default: ;
			endcase
		end
		latch_next = (latch_q | set_v) & ~clr_v;
	end

	always_comb begin
		rd = '0;
		if (acc.offset < FSEL_WORDS) begin
			rd = fsel_rd;
		end else begin
			case (acc.offset)
				WORD_LEV0: rd = acc.lev_lo;
				WORD_LEV1: rd = {{(LOW_WIDTH-HIGH_WIDTH){1'b0}},
					acc.lev_hi & HI_MASK[HIGH_WIDTH-1:0]};
				default:   rd = '0;
			endcase
		end
		if (acc.wr) begin
			rd = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latch_q <= '0;
			for (int i = 0; i < NUM_PINS; i++) begin
				fn_q[i] <= '0;
			end
		end else if (upd) begin
			latch_q <= latch_next;
			for (int i = 0; i < NUM_PINS; i++) begin
				fn_q[i] <= fn_next[i];
			end
		end
	end

	assign latch_ext = 64'(latch_next);
	assign en_ext    = 64'(en);

	assign res.read_data   = rd;
	assign res.drive_low   = latch_ext[LOW_WIDTH-1:0];
	assign res.drive_high  = latch_ext[LOW_WIDTH+HIGH_WIDTH-1:LOW_WIDTH];
	assign res.enable_low  = en_ext[LOW_WIDTH-1:0];
	assign res.enable_high = en_ext[LOW_WIDTH+HIGH_WIDTH-1:LOW_WIDTH];

endmodule

>>> design/gpio_bank_with_function_select.sv
// An accepted item is held in the input register acc_s1; its result is valid once registered in m_data_q.
// Throughput: one item per cycle; the input register and the result register
// advance together, so the block stalls only while a result waits on m_tready.
// Reset: arst_n clears all pin function codes (every pin an input), the output
// latch and both valid flags, asynchronously.
module gpio_bank_with_function_select import gpiofs_pkg::*; #(
	parameter int NUM_PINS = 54
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [95:0]  s_tdata,  // word_offset, write_data, pins_in_low, pins_in_high
	input  logic [0:0]   s_tuser,  // mode
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [143:0] m_tdata   // read_data, drive_low, drive_high, enable_low, enable_high
);

	gpiofs_acc_t acc_in;
	gpiofs_acc_t acc_s1;
	logic        v_s1;
	gpiofs_res_t res;
	logic        m_valid_q;
	logic [143:0] m_data_q;
	logic        adv_out;
	logic        adv1;

	assign acc_in.wr     = s_tuser[0];
	assign acc_in.offset = s_tdata[5:0];
	assign acc_in.wdata  = s_tdata[37:6];
	assign acc_in.lev_lo = s_tdata[69:38];
	assign acc_in.lev_hi = s_tdata[91:70];

	assign adv_out  = !m_valid_q || m_tready;
	assign adv1     = v_s1 && adv_out;
	assign s_tready = !v_s1 || adv_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				v_s1 <= s_tvalid;
			end
			if (adv_out) begin
				m_valid_q <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			acc_s1 <= acc_in;
		end
		if (adv1) begin
			m_data_q <= {4'b0, res.enable_high, res.enable_low, res.drive_high,
				res.drive_low, res.read_data};
		end
	end

	gpiofs_regfile #(
		.NUM_PINS(NUM_PINS)
	) u_regfile (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (adv1),
		.acc    (acc_s1),
		.res    (res)
	);

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule

>>> design/gpiofs_checker.sv
module gpiofs_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [143:0] m_tdata
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result changed while stalled");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |-> ##2 m_tvalid)
		else $error("no result two cycles after an accepted item");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tready || !m_tvalid) |-> s_tready)
		else $error("input stalled while output side can advance");

endmodule

bind gpio_bank_with_function_select gpiofs_checker u_gpiofs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
